[design/psbs_pkg.sv]
// Shared types and constants for the pixel sample background subtractor.
package psbs_pkg;

    localparam int SAMPLE_SLOTS_DEF = 16;
    localparam int MAX_PIXELS_DEF   = 131072;

    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int MMIN_W     = 5;
    localparam int WIDTH_W    = 10;
    localparam int HEIGHT_W   = 9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FG_HOLD_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_MINIMUM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd4;

    localparam logic [PIX_W-1:0]    DIFF_THRESHOLD_RST = 8'd10;
    localparam logic [PIX_W-1:0]    FG_HOLD_COUNT_RST  = 8'd4;
    localparam logic [MMIN_W-1:0]   MATCH_MINIMUM_RST  = 5'd2;
    localparam logic [WIDTH_W-1:0]  FRAME_WIDTH_RST    = 10'd320;
    localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST   = 9'd240;

    // Request kinds
    localparam logic KIND_UPDATE   = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel;
    } psbs_in_t;

    typedef struct packed {
        logic foreground;
        logic model_ready;
        logic frame_last;
    } psbs_out_t;

    // Per-request control carried down the pipeline
    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel;
        logic             learn;
        logic             fs_zero;
        logic             last;
        logic             ready;
    } psbs_ctl_t;

endpackage

[design/pixel_sample_background_subtractor_top.sv]
// Pixel sample background subtractor: four-stage pipeline over a per-pixel sample memory.
// A request passes through the stage 1, 2 and 3 registers and then the result register.
// Takes one request per cycle unless result back-pressure stalls the pipeline; any request
// to a pixel with an update still in flight (frames of 3 pixels or fewer) waits until
// that earlier write lands.
// After reset a clearing pass zeroes MAX_PIXELS rows, one per cycle, before requests are taken.
// A configuration write holds off requests in the cycle after it while the frame size settles.
module pixel_sample_background_subtractor_top #(
    parameter int SAMPLE_SLOTS = psbs_pkg::SAMPLE_SLOTS_DEF,
    parameter int MAX_PIXELS   = psbs_pkg::MAX_PIXELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pix_valid,
    output logic                            pix_ready,
    input  psbs_pkg::psbs_in_t              pix_data,
    output logic                            res_valid,
    input  logic                            res_ready,
    output psbs_pkg::psbs_out_t             res_data,
    input  logic                            cfg_wen,
    input  logic [psbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psbs_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int PW      = psbs_pkg::PIX_W;
    localparam int POS_W   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int TOT_W   = $clog2(MAX_PIXELS + 1);
    localparam int PROD_W  = psbs_pkg::WIDTH_W + psbs_pkg::HEIGHT_W;
    localparam int CMP_W   = (PROD_W > TOT_W) ? PROD_W : TOT_W;
    localparam int LAST_W  = ((POS_W + 1) > TOT_W) ? (POS_W + 1) : TOT_W;
    localparam int FS_W    = $clog2(SAMPLE_SLOTS + 2);
    localparam int SLOT_W  = $clog2(SAMPLE_SLOTS);
    localparam int ROW_W   = SAMPLE_SLOTS * PW;
    localparam int CNT_W   = $clog2(SAMPLE_SLOTS + 1);
    localparam int MC_W    = (CNT_W > psbs_pkg::MMIN_W) ? CNT_W : psbs_pkg::MMIN_W;
    localparam int GRP     = (SAMPLE_SLOTS + 3) / 4;

    // Configuration registers
    logic [PW-1:0]                  diff_threshold_reg;
    logic [PW-1:0]                  fg_hold_count_reg;
    logic [psbs_pkg::MMIN_W-1:0]    match_minimum_reg;
    logic [psbs_pkg::WIDTH_W-1:0]   frame_width_reg;
    logic [psbs_pkg::HEIGHT_W-1:0]  frame_height_reg;
    logic                           cfg_pend_reg;
    logic [TOT_W-1:0]               frame_total_reg;
    logic [TOT_W-1:0]               frame_total_next;
    logic [CMP_W-1:0]               frame_prod;

    // Sequencing state
    logic [POS_W-1:0]  pixel_position_reg;
    logic [FS_W-1:0]   frames_seen_reg;
    logic [SLOT_W-1:0] ring_slot_reg;
    logic              clr_active_reg;
    logic [POS_W-1:0]  clr_addr_reg;

    // Memories
    logic [ROW_W-1:0] sample_mem [MAX_PIXELS];
    logic [PW-1:0]    count_mem  [MAX_PIXELS];
    logic             mem_we;
    logic [POS_W-1:0] mem_addr;
    logic [ROW_W-1:0] mem_row_wdata;
    logic [PW-1:0]    mem_cnt_wdata;

    // Pipeline
    logic en1, en2, en3, en_out;
    logic accept, hazard, last_now, learn_now;
    psbs_pkg::psbs_ctl_t ctl_now;

    logic                s1_v_reg, s2_v_reg, s3_v_reg, res_v_reg;
    psbs_pkg::psbs_ctl_t s1_ctl_reg, s2_ctl_reg, s3_ctl_reg;
    logic [POS_W-1:0]    s1_pos_reg, s2_pos_reg, s3_pos_reg;
    logic [SLOT_W-1:0]   s1_fsi_reg, s2_fsi_reg, s3_fsi_reg;
    logic [SLOT_W-1:0]   s1_slot_reg, s2_slot_reg, s3_slot_reg;
    logic [ROW_W-1:0]    s1_row_reg, s2_row_reg, s3_row_reg;
    logic [PW-1:0]       s1_cnt_reg, s2_cnt_reg, s3_cnt_reg;

    logic [SAMPLE_SLOTS-1:0] s1_match, s1_match_l;
    logic [SAMPLE_SLOTS-1:0] s2_match_reg, s2_match_l_reg;
    logic [2:0]              s2_grp [GRP];
    logic [2:0]              s3_grp_reg [GRP];
    logic                    s3_any_l_reg;

    logic [CNT_W-1:0]    s3_sum;
    logic                s3_fg;
    logic [ROW_W-1:0]    s3_wr_row;
    logic [PW-1:0]       s3_wr_cnt;
    psbs_pkg::psbs_out_t res_data_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_threshold_reg <= psbs_pkg::DIFF_THRESHOLD_RST;
            fg_hold_count_reg  <= psbs_pkg::FG_HOLD_COUNT_RST;
            match_minimum_reg  <= psbs_pkg::MATCH_MINIMUM_RST;
            frame_width_reg    <= psbs_pkg::FRAME_WIDTH_RST;
            frame_height_reg   <= psbs_pkg::FRAME_HEIGHT_RST;
            cfg_pend_reg       <= 1'b1;
            frame_total_reg    <= '0;
        end
        else
        begin
            cfg_pend_reg    <= cfg_wen;
            frame_total_reg <= frame_total_next;
            if (cfg_wen)
            begin
                case (cfg_index)
                    psbs_pkg::REG_DIFF_THRESHOLD: diff_threshold_reg <= cfg_data[PW-1:0];
                    psbs_pkg::REG_FG_HOLD_COUNT:  fg_hold_count_reg  <= cfg_data[PW-1:0];
                    psbs_pkg::REG_MATCH_MINIMUM:
                        match_minimum_reg <= cfg_data[psbs_pkg::MMIN_W-1:0];
                    psbs_pkg::REG_FRAME_WIDTH:
                        frame_width_reg <= cfg_data[psbs_pkg::WIDTH_W-1:0];
                    psbs_pkg::REG_FRAME_HEIGHT:
                        frame_height_reg <= cfg_data[psbs_pkg::HEIGHT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Frame size: zero means one pixel, capped at the memory depth
    always_comb
    begin
        frame_prod = CMP_W'(frame_width_reg * frame_height_reg);
        if (frame_prod == '0)
            frame_total_next = TOT_W'(1);
        else if (frame_prod > CMP_W'(MAX_PIXELS))
            frame_total_next = TOT_W'(MAX_PIXELS);
        else
            frame_total_next = TOT_W'(frame_prod);
    end

    // ---------------- handshake and sequencing ----------------
    assign en_out = !res_v_reg || res_ready;
    assign en3    = !s3_v_reg || en_out;
    assign en2    = !s2_v_reg || en3;
    assign en1    = !s1_v_reg || en2;

    // Same pixel still awaiting its write-back
    assign hazard =
        (s1_v_reg && s1_ctl_reg.kind == psbs_pkg::KIND_UPDATE &&
         s1_pos_reg == pixel_position_reg) ||
        (s2_v_reg && s2_ctl_reg.kind == psbs_pkg::KIND_UPDATE &&
         s2_pos_reg == pixel_position_reg) ||
        (s3_v_reg && s3_ctl_reg.kind == psbs_pkg::KIND_UPDATE &&
         s3_pos_reg == pixel_position_reg);

    assign pix_ready = en1 && !hazard && !clr_active_reg && !cfg_pend_reg;
    assign accept    = pix_valid && pix_ready;

    assign last_now  = (LAST_W'(pixel_position_reg) + LAST_W'(1)) >= LAST_W'(frame_total_reg);
    assign learn_now = frames_seen_reg < FS_W'(SAMPLE_SLOTS);

    always_comb
    begin
        ctl_now.kind    = pix_data.kind;
        ctl_now.pixel   = pix_data.pixel;
        ctl_now.learn   = learn_now;
        ctl_now.fs_zero = (frames_seen_reg == '0);
        ctl_now.last    = last_now;
        ctl_now.ready   = frames_seen_reg > FS_W'(SAMPLE_SLOTS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_position_reg <= '0;
            frames_seen_reg    <= '0;
            ring_slot_reg      <= '0;
        end
        else if (accept)
        begin
            if (last_now)
            begin
                pixel_position_reg <= '0;
                if (pix_data.kind == psbs_pkg::KIND_UPDATE)
                begin
                    if (frames_seen_reg < FS_W'(SAMPLE_SLOTS + 1))
                        frames_seen_reg <= frames_seen_reg + FS_W'(1);
                    if (ring_slot_reg == SLOT_W'(SAMPLE_SLOTS - 1))
                        ring_slot_reg <= '0;
                    else
                        ring_slot_reg <= ring_slot_reg + SLOT_W'(1);
                end
            end
            else
            begin
                pixel_position_reg <= pixel_position_reg + POS_W'(1);
            end
        end
    end

    // Clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + POS_W'(1);
            if (clr_addr_reg == POS_W'(MAX_PIXELS - 1))
                clr_active_reg <= 1'b0;
        end
    end

    // ---------------- memories ----------------
    assign mem_we        = clr_active_reg ||
                           (s3_v_reg && en_out && s3_ctl_reg.kind == psbs_pkg::KIND_UPDATE);
    assign mem_addr      = clr_active_reg ? clr_addr_reg : s3_pos_reg;
    assign mem_row_wdata = clr_active_reg ? '0 : s3_wr_row;
    assign mem_cnt_wdata = clr_active_reg ? '0 : s3_wr_cnt;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[mem_addr] <= mem_row_wdata;
            count_mem[mem_addr]  <= mem_cnt_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_row_reg <= sample_mem[pixel_position_reg];
            s1_cnt_reg <= count_mem[pixel_position_reg];
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_v_reg <= accept;
            if (en2)
                s2_v_reg <= s1_v_reg;
            if (en3)
                s3_v_reg <= s2_v_reg;
            if (en_out)
                res_v_reg <= s3_v_reg;
        end
    end

    // ---------------- stage 1: sample compares ----------------
    always_comb
    begin
        logic [PW-1:0] smp;
        logic [PW-1:0] dif;
        for (int s = 0; s < SAMPLE_SLOTS; s++)
        begin
            smp = s1_row_reg[s*PW +: PW];
            dif = (smp > s1_ctl_reg.pixel) ? (smp - s1_ctl_reg.pixel)
                                           : (s1_ctl_reg.pixel - smp);
            s1_match[s]   = dif < diff_threshold_reg;
            s1_match_l[s] = s1_match[s] && (SLOT_W'(s) < s1_fsi_reg);
        end
    end

    // ---------------- stage 2: partial match counts ----------------
    always_comb
    begin
        for (int g = 0; g < GRP; g++)
        begin
            s2_grp[g] = '0;
            for (int j = 0; j < 4; j++)
            begin
                if (g * 4 + j < SAMPLE_SLOTS)
                    s2_grp[g] = s2_grp[g] + 3'(s2_match_reg[g*4+j]);
            end
        end
    end

    // ---------------- stage 3: decision and write-back data ----------------
    always_comb
    begin
        s3_sum = '0;
        for (int g = 0; g < GRP; g++)
            s3_sum = s3_sum + CNT_W'(s3_grp_reg[g]);

        s3_fg     = 1'b0;
        s3_wr_row = s3_row_reg;
        s3_wr_cnt = s3_cnt_reg;

        if (s3_ctl_reg.kind == psbs_pkg::KIND_CLASSIFY)
        begin
            s3_fg = MC_W'(s3_sum) < MC_W'(match_minimum_reg);
        end
        else if (s3_ctl_reg.learn)
        begin
            for (int s = 0; s < SAMPLE_SLOTS; s++)
            begin
                if (s3_ctl_reg.fs_zero ? (s == 0)
                                       : (s3_any_l_reg && SLOT_W'(s) == s3_fsi_reg))
                    s3_wr_row[s*PW +: PW] = s3_ctl_reg.pixel;
            end
        end
        else if (MC_W'(s3_sum) >= MC_W'(match_minimum_reg))
        begin
            s3_wr_row = {SAMPLE_SLOTS{s3_ctl_reg.pixel}};
            s3_wr_cnt = '0;
        end
        else
        begin
            s3_fg     = 1'b1;
            s3_wr_cnt = s3_cnt_reg + PW'(1);
            for (int s = 0; s < SAMPLE_SLOTS; s++)
            begin
                if (s3_wr_cnt > fg_hold_count_reg && SLOT_W'(s) == s3_slot_reg)
                    s3_wr_row[s*PW +: PW] = s3_ctl_reg.pixel;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_ctl_reg  <= ctl_now;
            s1_pos_reg  <= pixel_position_reg;
            s1_fsi_reg  <= frames_seen_reg[SLOT_W-1:0];
            s1_slot_reg <= ring_slot_reg;
        end
        if (en2)
        begin
            s2_ctl_reg     <= s1_ctl_reg;
            s2_pos_reg     <= s1_pos_reg;
            s2_fsi_reg     <= s1_fsi_reg;
            s2_slot_reg    <= s1_slot_reg;
            s2_row_reg     <= s1_row_reg;
            s2_cnt_reg     <= s1_cnt_reg;
            s2_match_reg   <= s1_match;
            s2_match_l_reg <= s1_match_l;
        end
        if (en3)
        begin
            s3_ctl_reg   <= s2_ctl_reg;
            s3_pos_reg   <= s2_pos_reg;
            s3_fsi_reg   <= s2_fsi_reg;
            s3_slot_reg  <= s2_slot_reg;
            s3_row_reg   <= s2_row_reg;
            s3_cnt_reg   <= s2_cnt_reg;
            s3_grp_reg   <= s2_grp;
            s3_any_l_reg <= |s2_match_l_reg;
        end
        if (en_out)
        begin
            res_data_reg.foreground  <= s3_fg;
            res_data_reg.model_ready <= s3_ctl_reg.ready;
            res_data_reg.frame_last  <= s3_ctl_reg.last;
        end
    end

    assign res_valid = res_v_reg;
    assign res_data  = res_data_reg;

endmodule

[design/psbs_checker.sv]
// Port-level checker for the background subtractor, bound to the top level.
module psbs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            pix_valid,
    input logic                            pix_ready,
    input logic                            res_valid,
    input logic                            res_ready,
    input psbs_pkg::psbs_out_t             res_data,
    input logic                            cfg_wen
);

    logic [2:0] pending_reg;
    logic       ready_seen_reg;
    logic       req_take, res_take;

    assign req_take = pix_valid && pix_ready;
    assign res_take = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            ready_seen_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(req_take) - 3'(res_take);
            if (res_take && res_data.model_ready)
                ready_seen_reg <= 1'b1;
        end
    end

    // A result only for a request already taken
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != '0)
        else $error("result without pending request");

    // Four pipeline slots at most
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("more requests in flight than pipeline slots");

    // The model never falls back to learning
    a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && ready_seen_reg) |-> res_data.model_ready)
        else $error("model_ready dropped");

    // Requests are held off in the cycle after a register write while the frame size settles
    a_cfg_gap: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wen |=> !pix_ready)
        else $error("request taken right after configuration write");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
        else $error("stalled result changed");

endmodule

bind pixel_sample_background_subtractor_top psbs_checker u_psbs_checker (.*);

[verif/tb_top.sv]
// Self-checking testbench for the pixel sample background subtractor.
`timescale 1ns / 100ps

module tb_top;

    localparam int SLOTS     = psbs_pkg::SAMPLE_SLOTS_DEF;
    localparam int PIX_CAP   = psbs_pkg::MAX_PIXELS_DEF;
    localparam int CFG_W     = psbs_pkg::CFG_DATA_W;
    localparam int LIMIT     = 1000000;
    localparam int SCENE_LEN = 64;

    logic                            clk;
    logic                            rst_n;
    logic                            pix_valid;
    logic                            pix_ready;
    psbs_pkg::psbs_in_t              pix_data;
    logic                            res_valid;
    logic                            res_ready;
    psbs_pkg::psbs_out_t             res_data;
    logic                            cfg_wen;
    logic [psbs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [psbs_pkg::CFG_DATA_W-1:0] cfg_data;

    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned cycles;
    logic [7:0]  scene [SCENE_LEN];

    // Tracks per-pixel samples and run counters, predicts each verdict
    class bgsub_scoreboard;
        logic [7:0]                     sample_mem [int];
        logic [7:0]                     fg_run [int];
        int unsigned                    frames_seen;
        int unsigned                    ring_slot;
        int unsigned                    position;
        logic [7:0]                     diff_threshold;
        logic [7:0]                     fg_hold_count;
        logic [psbs_pkg::MMIN_W-1:0]    match_minimum;
        logic [psbs_pkg::WIDTH_W-1:0]   frame_width;
        logic [psbs_pkg::HEIGHT_W-1:0]  frame_height;
        psbs_pkg::psbs_out_t            verdicts [$];
        int unsigned                    mismatches;
        int unsigned                    results_seen;

        function new();
            frames_seen    = 0;
            ring_slot      = 0;
            position       = 0;
            diff_threshold = psbs_pkg::DIFF_THRESHOLD_RST;
            fg_hold_count  = psbs_pkg::FG_HOLD_COUNT_RST;
            match_minimum  = psbs_pkg::MATCH_MINIMUM_RST;
            frame_width    = psbs_pkg::FRAME_WIDTH_RST;
            frame_height   = psbs_pkg::FRAME_HEIGHT_RST;
            mismatches     = 0;
            results_seen   = 0;
        endfunction

        function void set_reg(logic [psbs_pkg::CFG_IDX_W-1:0] idx,
                              logic [psbs_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                psbs_pkg::REG_DIFF_THRESHOLD: diff_threshold = val[7:0];
                psbs_pkg::REG_FG_HOLD_COUNT:  fg_hold_count  = val[7:0];
                psbs_pkg::REG_MATCH_MINIMUM:  match_minimum  = val[psbs_pkg::MMIN_W-1:0];
                psbs_pkg::REG_FRAME_WIDTH:    frame_width    = val[psbs_pkg::WIDTH_W-1:0];
                psbs_pkg::REG_FRAME_HEIGHT:   frame_height   = val[psbs_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        // the store is cleared at reset, so unwritten entries read as zero
        function logic [7:0] stored(int unsigned pos, int unsigned s);
            int key;
            key = int'(pos * SLOTS + s);
            return sample_mem.exists(key) ? sample_mem[key] : 8'd0;
        endfunction

        function logic [7:0] run_length(int unsigned pos);
            return fg_run.exists(int'(pos)) ? fg_run[int'(pos)] : 8'd0;
        endfunction

        function int unsigned close_samples(int unsigned pos, int unsigned n, logic [7:0] px);
            int unsigned hits;
            int unsigned s;
            int unsigned d;
            logic [7:0]  v;
            hits = 0;
            for (s = 0; s < n; s++)
            begin
                v = stored(pos, s);
                d = (v > px) ? 32'(v - px) : 32'(px - v);
                if (d < diff_threshold)
                    hits++;
            end
            return hits;
        endfunction

        function psbs_pkg::psbs_out_t classify_and_learn(psbs_pkg::psbs_in_t req);
            psbs_pkg::psbs_out_t res;
            int unsigned         total;
            int unsigned         pos;
            int unsigned         s;
            logic [7:0]          run;
            logic                is_last;
            logic                is_ready;
            logic                fg;
            total = 32'(frame_width) * 32'(frame_height);
            if (total == 0)
                total = 1;
            if (total > PIX_CAP)
                total = PIX_CAP;
            pos      = position;
            is_last  = (pos + 1 >= total);
            is_ready = (frames_seen > SLOTS);
            fg       = 1'b0;

            if (req.kind == psbs_pkg::KIND_CLASSIFY)
                fg = (close_samples(pos, SLOTS, req.pixel) < match_minimum);
            else if (frames_seen < SLOTS)
            begin
                // learning: frame f fills slot f, after frame 0 only on a match
                if (frames_seen == 0)
                    sample_mem[int'(pos * SLOTS)] = req.pixel;
                else if (close_samples(pos, frames_seen, req.pixel) > 0)
                    sample_mem[int'(pos * SLOTS + frames_seen)] = req.pixel;
            end
            else if (close_samples(pos, SLOTS, req.pixel) >= match_minimum)
            begin
                for (s = 0; s < SLOTS; s++)
                    sample_mem[int'(pos * SLOTS + s)] = req.pixel;
                fg_run[int'(pos)] = 8'd0;
            end
            else
            begin
                fg  = 1'b1;
                run = run_length(pos) + 8'd1;
                fg_run[int'(pos)] = run;
                if (run > fg_hold_count)
                    sample_mem[int'(pos * SLOTS + ring_slot)] = req.pixel;
            end

            if (is_last)
            begin
                position = 0;
                if (req.kind == psbs_pkg::KIND_UPDATE)
                begin
                    if (frames_seen < SLOTS + 1)
                        frames_seen++;
                    ring_slot = (ring_slot + 1) % SLOTS;
                end
            end
            else
                position = pos + 1;

            res.foreground  = fg;
            res.model_ready = is_ready;
            res.frame_last  = is_last;
            return res;
        endfunction

        function void note_request(psbs_pkg::psbs_in_t req);
            verdicts.push_back(classify_and_learn(req));
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task check_result(psbs_pkg::psbs_out_t got);
            psbs_pkg::psbs_out_t want;
            results_seen++;
            if (verdicts.size() == 0)
            begin
                report($sformatf("result %0d arrived with no request pending", results_seen));
                return;
            end
            want = verdicts.pop_front();
            if (got.foreground !== want.foreground)
                report($sformatf("result %0d foreground got %b want %b",
                                 results_seen, got.foreground, want.foreground));
            if (got.model_ready !== want.model_ready)
                report($sformatf("result %0d model_ready got %b want %b",
                                 results_seen, got.model_ready, want.model_ready));
            if (got.frame_last !== want.frame_last)
                report($sformatf("result %0d frame_last got %b want %b",
                                 results_seen, got.frame_last, want.frame_last));
        endtask
    endclass

    bgsub_scoreboard board;

    pixel_sample_background_subtractor_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side: check on handshake, then pick next cycle's stall
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            board.check_result(res_data);
        res_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_request(input psbs_pkg::psbs_in_t req);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= req;
        @(posedge clk);
        while (!pix_ready)
            @(posedge clk);
        board.note_request(req);
    endtask

    task automatic push(input logic kind, input logic [7:0] px);
        psbs_pkg::psbs_in_t req;
        req.kind  = kind;
        req.pixel = px;
        send_request(req);
    endtask

    // sender holds off until every pending request has its result
    task automatic wait_idle();
        pix_valid <= 1'b0;
        while (board.verdicts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [psbs_pkg::CFG_IDX_W-1:0] idx, input int val);
        logic [psbs_pkg::CFG_DATA_W-1:0] data;
        data = CFG_W'(val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wen <= 1'b0;
        board.set_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic run_phase(input int n, input int w, input int h, input int thr,
                             input int hold, input int mmin, input int src_pct,
                             input int sink_pct, input int upd_pct, input int obj_pct);
        psbs_pkg::psbs_in_t req;
        int                 jit;
        int                 level;
        wait_idle();
        write_reg(psbs_pkg::REG_DIFF_THRESHOLD, thr);
        write_reg(psbs_pkg::REG_FG_HOLD_COUNT, hold);
        write_reg(psbs_pkg::REG_MATCH_MINIMUM, mmin);
        write_reg(psbs_pkg::REG_FRAME_WIDTH, w);
        write_reg(psbs_pkg::REG_FRAME_HEIGHT, h);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        foreach (scene[i])
        begin
            case ($urandom_range(0, 9))
                0:       scene[i] = 8'd0;
                1:       scene[i] = 8'd255;
                default: scene[i] = 8'($urandom_range(0, 255));
            endcase
        end
        // jitter inside the threshold keeps most pixels matching their scene value
        jit = (thr > 2) ? thr / 2 : 1;
        repeat (n)
        begin
            req.kind = ($urandom_range(0, 99) < upd_pct) ? psbs_pkg::KIND_UPDATE
                                                         : psbs_pkg::KIND_CLASSIFY;
            if ($urandom_range(0, 99) < obj_pct)
                req.pixel = 8'($urandom_range(0, 255));
            else
            begin
                level = int'(scene[board.position % SCENE_LEN])
                      + int'($urandom_range(0, 2 * jit)) - jit;
                req.pixel = (level < 0) ? 8'd0 : (level > 255) ? 8'd255 : 8'(level);
            end
            send_request(req);
        end
    endtask

    initial
    begin
        board          = new();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        rst_n     <= 1'b0;
        pix_valid <= 1'b0;
        pix_data  <= '0;
        cfg_wen   <= 1'b0;
        cfg_index <= psbs_pkg::REG_DIFF_THRESHOLD;
        cfg_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // frame 0 at reset size: extremes of both fields
        push(psbs_pkg::KIND_UPDATE, 8'd0);
        push(psbs_pkg::KIND_UPDATE, 8'd255);
        push(psbs_pkg::KIND_CLASSIFY, 8'd0);
        push(psbs_pkg::KIND_CLASSIFY, 8'd255);
        push(psbs_pkg::KIND_UPDATE, 8'd128);
        // frame exactly at the pixel cap
        wait_idle();
        write_reg(psbs_pkg::REG_FRAME_WIDTH, 512);
        write_reg(psbs_pkg::REG_FRAME_HEIGHT, 256);
        push(psbs_pkg::KIND_UPDATE, 8'd1);
        push(psbs_pkg::KIND_CLASSIFY, 8'd254);
        // oversized frame, capped
        wait_idle();
        write_reg(psbs_pkg::REG_FRAME_WIDTH, 1023);
        write_reg(psbs_pkg::REG_FRAME_HEIGHT, 511);
        push(psbs_pkg::KIND_UPDATE, 8'd127);
        push(psbs_pkg::KIND_CLASSIFY, 8'd128);
        // shrink to one pixel mid-frame: next request closes the frame
        wait_idle();
        write_reg(psbs_pkg::REG_FRAME_WIDTH, 1);
        write_reg(psbs_pkg::REG_FRAME_HEIGHT, 1);
        push(psbs_pkg::KIND_UPDATE, 8'd0);
        push(psbs_pkg::KIND_UPDATE, 8'd3);
        push(psbs_pkg::KIND_UPDATE, 8'd200);
        push(psbs_pkg::KIND_CLASSIFY, 8'd0);
        push(psbs_pkg::KIND_CLASSIFY, 8'd200);
        push(psbs_pkg::KIND_UPDATE, 8'd255);

        //        n    w    h    thr  hold mmin src sink upd obj
        run_phase(150, 4,   2,   12,  4,   2,   0,  0,   85, 5);
        run_phase(250, 5,   3,   20,  2,   3,   54, 0,   80, 15);
        run_phase(250, 3,   1,   10,  0,   16,  0,  54,  80, 20);
        run_phase(200, 1,   2,   255, 255, 1,   9,  9,   70, 30);
        // no sample can match: long foreground run wraps the counter
        run_phase(270, 1,   1,   0,   3,   2,   0,  0,   100, 0);
        run_phase(200, 0,   7,   30,  10,  0,   54, 0,   75, 20);
        run_phase(80,  9,   0,   40,  255, 1,   9,  9,   80, 20);
        run_phase(200, 7,   3,   8,   1,   31,  0,  54,  80, 20);
        run_phase(200, 6,   4,   16,  6,   4,   9,  9,   85, 10);

        wait_idle();
        if (board.verdicts.size() != 0)
            board.report("requests left without a result");
        if (board.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
design/psbs_pkg.sv
design/pixel_sample_background_subtractor_top.sv
design/psbs_checker.sv
verif/tb_top.sv
